// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hebp_pkg.sv -----
// ---------------------------------------------------------------------------
// hebp_pkg
// Shared types and constants of the Huffman encoder bit packer.
// ---------------------------------------------------------------------------
package hebp_pkg;

	// Input item kinds
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ENC   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam int SYM_W   = 8;
	localparam int CLEN_W  = 5;
	localparam int CBITS_W = 20;
	localparam int TBL_DEPTH = 256;

	// Stream constants
	localparam logic [7:0] ESC_VAL   = 8'd26;
	localparam logic [7:0] ASCII_ZRO = 8'h30;
	localparam logic [7:0] ASCII_ONE = 8'h31;

	// Controller to datapath
	typedef struct packed {
		logic tbl_wr;      // write table entry from input
		logic tbl_rd;      // read table entry for input symbol
		logic load_code;   // load looked-up code into packer
		logic start_flush; // set up zero padding
		logic step;        // shift one chunk into accumulator
		logic emit_byte;   // send completed byte
		logic emit_esc;    // send one escape character
		logic emit_mark;   // send one end marker character
	} hebp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rem_zero;  // no code bits left
		logic byte_done; // next chunk completes a byte
		logic byte_esc;  // completed byte needs escaping
		logic slot_free; // output register can take a result
		logic cnt_last;  // character counter at final position
		logic flush;     // current item is a flush
	} hebp_sts_t;

endpackage

// ----- design/hebp_datapath.sv -----
// ---------------------------------------------------------------------------
// hebp_datapath
// Code table, MSB-first packing accumulator, character counter and output
// register of the Huffman encoder bit packer.
// ---------------------------------------------------------------------------
module hebp_datapath import hebp_pkg::*; #(
	parameter int MAX_CODE_LEN = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hebp_cmd_t           cmd,
	output hebp_sts_t           sts,
	input  logic [SYM_W-1:0]    symbol,
	input  logic [CLEN_W-1:0]   code_length,
	input  logic [CBITS_W-1:0]  code_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic [3:0]          out_pad
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int CMP_W = (LEN_W > CLEN_W) ? LEN_W : CLEN_W;

	// Table storage
	logic [LEN_W-1:0]   len_mem [TBL_DEPTH];
	logic [CBITS_W-1:0] bits_mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;
	logic [LEN_W-1:0]   rd_len_q;
	logic [CBITS_W-1:0] rd_bits_q;
	logic               rd_vld_q;

	// Packer state
	logic [7:0]         acc_q;
	logic [2:0]         held_q;
	logic [LEN_W-1:0]   rem_q;
	logic [CBITS_W-1:0] code_q;
	logic [3:0]         pad_q;
	logic               flush_q;
	logic [2:0]         cnt_q;
	logic               esc_last_q;

	// Output register
	logic               ovld_q;
	logic [7:0]         obyte_q;
	logic               olast_q;
	logic [3:0]         opad_q;

	logic [CMP_W-1:0]   len_ext;
	logic [CMP_W-1:0]   len_clamp;
	logic [3:0]         room;
	logic [3:0]         take;
	logic [LEN_W-1:0]   shr;
	logic [CBITS_W-1:0] code_sh;
	logic [7:0]         mask;
	logic [7:0]         chunk;
	logic [7:0]         acc_new;
	logic [3:0]         held_sum;
	logic               rem_lt8;
	logic               slot_free;
	logic [7:0]         esc_char;

	// Clamp loaded length
	assign len_ext   = CMP_W'(code_length);
	assign len_clamp = (len_ext > CMP_W'(MAX_CODE_LEN)) ? CMP_W'(MAX_CODE_LEN) : len_ext;

	// Write table entry
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			len_mem[symbol]  <= LEN_W'(len_clamp);
			bits_mem[symbol] <= code_bits;
		end
	end

	// Registered table read
	always_ff @(posedge clk) begin
		if (cmd.tbl_rd) begin
			rd_len_q  <= len_mem[symbol];
			rd_bits_q <= bits_mem[symbol];
		end
	end

	// Entry valid bits; an unwritten entry reads as length zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.tbl_wr)
				vld_q[symbol] <= 1'b1;
			if (cmd.tbl_rd)
				rd_vld_q <= vld_q[symbol];
		end
	end

	// Chunk of code bits that fits the room left in the accumulator
	assign room     = 4'd8 - {1'b0, held_q};
	assign take     = (rem_q < LEN_W'(room)) ? 4'(rem_q) : room;
	assign shr      = rem_q - LEN_W'(take);
	assign code_sh  = code_q >> shr;
	assign mask     = 8'((9'd1 << take) - 9'd1);
	assign chunk    = code_sh[7:0] & mask;
	assign acc_new  = acc_q | 8'(chunk << (room - take));
	assign held_sum = {1'b0, held_q} + take;
	assign rem_lt8  = (shr < LEN_W'(8));

	assign slot_free = !ovld_q || out_ready;
	assign esc_char  = ESC_VAL[3'd7 - cnt_q] ? ASCII_ONE : ASCII_ZRO;

	// Packer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			held_q     <= '0;
			rem_q      <= '0;
			code_q     <= '0;
			pad_q      <= '0;
			flush_q    <= 1'b0;
			cnt_q      <= '0;
			esc_last_q <= 1'b0;
		end else begin
			if (cmd.load_code) begin
				rem_q   <= rd_vld_q ? rd_len_q : '0;
				code_q  <= rd_bits_q;
				pad_q   <= '0;
				flush_q <= 1'b0;
				cnt_q   <= '0;
			end
			if (cmd.start_flush) begin
				rem_q   <= LEN_W'(room);
				code_q  <= '0;
				pad_q   <= room;
				flush_q <= 1'b1;
				cnt_q   <= '0;
			end
			if (cmd.step) begin
				rem_q      <= shr;
				esc_last_q <= !flush_q && rem_lt8;
				if (held_sum[3]) begin
					acc_q  <= '0;
					held_q <= '0;
				end else begin
					acc_q  <= acc_new;
					held_q <= held_sum[2:0];
				end
			end
			if (cmd.emit_esc || cmd.emit_mark)
				cnt_q <= cnt_q + 3'd1;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovld_q <= 1'b0;
		else if (cmd.emit_byte || cmd.emit_esc || cmd.emit_mark)
			ovld_q <= 1'b1;
		else if (out_ready)
			ovld_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_byte) begin
			obyte_q <= acc_new;
			olast_q <= !flush_q && rem_lt8;
			opad_q  <= pad_q;
		end else if (cmd.emit_esc) begin
			obyte_q <= esc_char;
			olast_q <= esc_last_q && (cnt_q == 3'd7);
			opad_q  <= pad_q;
		end else if (cmd.emit_mark) begin
			obyte_q <= ASCII_ZRO;
			olast_q <= (cnt_q == 3'd7);
			opad_q  <= pad_q;
		end
	end

	assign out_valid = ovld_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;
	assign out_pad   = opad_q;

	assign sts.rem_zero  = (rem_q == '0);
	assign sts.byte_done = held_sum[3];
	assign sts.byte_esc  = (acc_new == ESC_VAL);
	assign sts.slot_free = slot_free;
	assign sts.cnt_last  = (cnt_q == 3'd7);
	assign sts.flush     = flush_q;

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_emit_slot, cmd.emit_byte || cmd.emit_esc || cmd.emit_mark, slot_free, "emit into a full output register")
	`ASSERT_IMPL(a_emit_one, 1'b1, $onehot0({cmd.emit_byte, cmd.emit_esc, cmd.emit_mark}), "two results emitted at once")
	`ASSERT_IMPL(a_step_bits, cmd.step, rem_q != '0, "packing step with no bits left")
	`ASSERT_NEXT(a_flush_align, cmd.start_flush, (held_sum[3] && flush_q), "flush padding does not reach a byte boundary")

endmodule

// ----- design/hebp_ctrl.sv -----
// ---------------------------------------------------------------------------
// hebp_ctrl
// Sequencer of the Huffman encoder bit packer: takes one item at a time and
// walks the datapath through lookup, packing, escaping and end marker.
// ---------------------------------------------------------------------------
module hebp_ctrl import hebp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  hebp_sts_t  sts,
	output hebp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOKUP = 6'b000010,
		S_PACK   = 6'b000100,
		S_ESC    = 6'b001000,
		S_MARK   = 6'b010000,
		S_FLUSH  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   take_item;

	assign in_ready  = (state_q == S_IDLE);
	assign take_item = in_valid && in_ready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (take_item) begin
					case (in_op)
						OP_LOAD: cmd.tbl_wr = 1'b1;
						OP_ENC: begin
							cmd.tbl_rd = 1'b1;
							state_d    = S_LOOKUP;
						end
						OP_FLUSH: begin
							cmd.start_flush = 1'b1;
							state_d         = S_FLUSH;
						end
						default: ;
					endcase
				end
			end
			S_LOOKUP: begin
				cmd.load_code = 1'b1;
				state_d       = S_PACK;
			end
			S_FLUSH, S_PACK: begin
				if (sts.rem_zero) begin
					state_d = S_IDLE;
				end else if (!sts.byte_done) begin
					cmd.step = 1'b1;
					state_d  = S_PACK;
				end else if (sts.slot_free) begin
					cmd.step = 1'b1;
					if (sts.byte_esc) begin
						state_d = S_ESC;
					end else begin
						cmd.emit_byte = 1'b1;
						state_d       = sts.flush ? S_MARK : S_PACK;
					end
				end
			end
			S_ESC: begin
				if (sts.slot_free) begin
					cmd.emit_esc = 1'b1;
					if (sts.cnt_last)
						state_d = sts.flush ? S_MARK : S_PACK;
				end
			end
			S_MARK: begin
				if (sts.slot_free) begin
					cmd.emit_mark = 1'b1;
					if (sts.cnt_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_rd_lookup, cmd.tbl_rd, state_q == S_LOOKUP, "table read not followed by lookup")
	`ASSERT_NEXT(a_mark_done, (state_q == S_MARK) && cmd.emit_mark && sts.cnt_last, in_ready, "end marker does not return to idle")

endmodule

// ----- design/huffman_encode_bit_packer.sv -----
// ---------------------------------------------------------------------------
// huffman_encode_bit_packer
// Huffman code table with an MSB-first byte packer, byte escaping and a
// zero-padding flush that closes the stream with an end marker.
//
// Channel  Dir  tdata                                        tuser     tlast
// s_*      in   symbol, code_length, code_bits (40b)         opcode    -
// m_*      out  out_byte, pad_count (16b)                    -         last
//
// Load: a table write from the idle state. Symbol: a table lookup, then
// packing steps on chunks of up to 8 code bits (at most 4 chunks for a
// 20-bit code), a closing step, plus 8 escape characters per escaped byte.
// Flush: padding, then 8 marker characters (+8 escape ones if escaped). One
// item is in work at a time; the sequencer FSM and the output register set
// the pace. Results wait while m_tready is low, and input is held off.
// Reset clears the table valid bits and the packer at once; no clearing pass.
// ---------------------------------------------------------------------------
module huffman_encode_bit_packer import hebp_pkg::*; #(
	parameter int MAX_CODE_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // symbol[7:0], code_length[12:8], code_bits[32:13], zero
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], pad_count[11:8], zero
	output logic        m_tlast
);

	hebp_cmd_t  cmd;
	hebp_sts_t  sts;
	logic [7:0] out_byte;
	logic [3:0] out_pad;

	hebp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hebp_datapath #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.symbol      (s_tdata[7:0]),
		.code_length (s_tdata[12:8]),
		.code_bits   (s_tdata[32:13]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (out_byte),
		.out_last    (m_tlast),
		.out_pad     (out_pad)
	);

	assign m_tdata = {4'b0, out_pad, out_byte};

endmodule

// ----- tb/sv/huffman_encode_bit_packer_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// huffman_encode_bit_packer_checker
// Watches both stream channels of the Huffman bit packer. Every accepted
// input transfer is run through a local copy of the code table and the byte
// packer, and the resulting output bytes are queued. Every accepted output
// transfer is compared field by field with the oldest queued byte.
// ---------------------------------------------------------------------------
module huffman_encode_bit_packer_checker import hebp_pkg::*; #(
	parameter int MAX_CODE_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // symbol[7:0], code_length[12:8], code_bits[32:13], zero
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // out_byte[7:0], pad_count[11:8], zero
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [3:0] pad_count;
	} packed_byte_t;

	// Local code table and packer state
	logic [CLEN_W-1:0]  code_len [TBL_DEPTH];
	logic [CBITS_W-1:0] code_val [TBL_DEPTH];
	logic [7:0]         acc;
	int                 held;
	packed_byte_t       expected_bytes[$];

	task automatic queue_byte(input logic [7:0] value, input logic [3:0] pad);
		packed_byte_t entry;
		entry.out_byte  = value;
		entry.last      = 1'b0;
		entry.pad_count = pad;
		expected_bytes.push_back(entry);
	endtask

	// Expand a completed byte of the escape value into its ASCII digits
	task automatic emit_packed(input logic [7:0] value, input logic [3:0] pad);
		if (value == ESC_VAL) begin
			for (int i = 7; i >= 0; i--)
				queue_byte(ESC_VAL[i] ? ASCII_ONE : ASCII_ZRO, pad);
		end else begin
			queue_byte(value, pad);
		end
	endtask

	// Fill the accumulator from bit 7 downward
	task automatic shift_in(input logic b, input logic [3:0] pad);
		if (b)
			acc[7 - held] = 1'b1;
		held++;
		if (held == 8) begin
			emit_packed(acc, pad);
			acc  = 8'd0;
			held = 0;
		end
	endtask

	task automatic pack_item(input logic [1:0] op, input logic [7:0] sym,
			input logic [4:0] len, input logic [19:0] code);
		int first;
		int pad;
		first = expected_bytes.size();
		case (op)
			OP_LOAD: begin
				code_len[sym] = (len > MAX_CODE_LEN) ? CLEN_W'(MAX_CODE_LEN) : len;
				code_val[sym] = code;
			end
			OP_ENC: begin
				for (int i = int'(code_len[sym]) - 1; i >= 0; i--)
					shift_in((i < CBITS_W) ? code_val[sym][i] : 1'b0, 4'd0);
			end
			OP_FLUSH: begin
				pad = 8 - held;
				repeat (pad) shift_in(1'b0, 4'(pad));
				repeat (8) queue_byte(ASCII_ZRO, 4'(pad));
			end
			default: ;
		endcase
		// Mark the final byte caused by this transfer
		if (expected_bytes.size() > first)
			expected_bytes[expected_bytes.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		packed_byte_t want;
		if (!arst_n) begin
			for (int k = 0; k < TBL_DEPTH; k++) begin
				code_len[k] = '0;
				code_val[k] = '0;
			end
			acc  = 8'd0;
			held = 0;
			expected_bytes.delete();
			pending = 0;
		end else begin
			// Compare an output transfer with the oldest expected byte
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result: out_byte %0h, pad_count %0d, last %0b",
						m_tdata[7:0], m_tdata[11:8], m_tlast);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata[7:0] !== want.out_byte) begin
						$error("out_byte: expected %0h, actual %0h", want.out_byte, m_tdata[7:0]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, m_tlast);
						errors++;
					end
					if (m_tdata[11:8] !== want.pad_count) begin
						$error("pad_count: expected %0d, actual %0d", want.pad_count,
							m_tdata[11:8]);
						errors++;
					end
				end
			end
			// Predict the bytes of an input transfer
			if (s_tvalid && s_tready)
				pack_item(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[32:13]);
			pending = expected_bytes.size();
		end
	end

endmodule

// ----- tb/sv/huffman_encode_bit_packer_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// huffman_encode_bit_packer_tb
// Drives table loads, symbols and flushes into the Huffman bit packer with
// random gaps on the input and random stalls on the output. A directed part
// covers field extremes, escaped bytes, aligned flushes, absent symbols,
// overlong loads and the unused opcode; a random part follows. The checker
// beside the block reports mismatches; this module gives the verdict.
// ---------------------------------------------------------------------------
module huffman_encode_bit_packer_tb;
	import hebp_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 350;
	localparam int STALL_PCT    = 12;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 64;
	localparam int SYM_POOL     = 16;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        calm     = 1'b0;
	int          errors;
	int          pending;
	int          quiet_cycles = 0;

	always #1 clk = ~clk;

	huffman_encode_bit_packer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	huffman_encode_bit_packer_checker stream_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	// Stall the output at random, except in the calm stretch
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// Count cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Present one item after an optional gap and hold it until accepted
	task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
			input logic [4:0] len, input logic [19:0] code);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, code, len, sym};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin : stimulus
		int          counted;
		int          pick;
		bit          paused;
		logic [1:0]  op;
		logic [7:0]  sym;
		logic [4:0]  len;
		logic [19:0] code;

		counted = 0;
		paused  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		send_item(OP_FLUSH, 8'd0, 5'd0, 20'd0);           // aligned flush right after reset
		send_item(OP_ENC, 8'd0, 5'd0, 20'd0);             // absent symbol, empty table
		send_item(OP_NONE, 8'hFF, 5'h1F, 20'hFFFFF);      // unused opcode
		send_item(OP_LOAD, 8'hFF, 5'h1F, 20'hFFFFF);      // overlong load
		send_item(OP_LOAD, 8'd0, 5'd8, 20'(ESC_VAL));     // code that forms the escape value
		send_item(OP_LOAD, 8'd1, 5'd1, 20'd1);
		send_item(OP_LOAD, 8'd2, 5'd3, 20'd0);
		send_item(OP_LOAD, 8'd3, 5'd0, 20'hA5A5A);        // absent entry with stale bits
		send_item(OP_ENC, 8'd0, 5'd0, 20'd0);             // escaped byte
		send_item(OP_ENC, 8'hFF, 5'd0, 20'd0);
		send_item(OP_ENC, 8'd3, 5'd0, 20'd0);
		send_item(OP_ENC, 8'd1, 5'd0, 20'd0);
		send_item(OP_ENC, 8'd2, 5'd0, 20'd0);
		send_item(OP_ENC, 8'hFF, 5'd0, 20'd0);
		send_item(OP_FLUSH, 8'hFF, 5'h1F, 20'hFFFFF);     // unaligned flush
		send_item(OP_LOAD, 8'd128, 5'd20, 20'h00000);
		send_item(OP_ENC, 8'd128, 5'd0, 20'd0);
		send_item(OP_LOAD, 8'd128, 5'd21, 20'h55555);
		send_item(OP_ENC, 8'd128, 5'd0, 20'd0);
		send_item(OP_ENC, 8'd1, 5'd0, 20'd0);
		send_item(OP_FLUSH, 8'd0, 5'd0, 20'd0);
		send_item(OP_FLUSH, 8'd0, 5'd0, 20'd0);

		// Random part: mostly symbols from a small pool of loaded entries
		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= 150 && counted < 230);
			if (counted == 100 && !paused) begin
				// Hold off input until every byte has come out
				paused = 1'b1;
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			sym  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SYM_POOL - 1))
				: 8'($urandom_range(0, 255));
			code = 20'($urandom);
			len  = 5'($urandom_range(1, 20));
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				op   = OP_LOAD;
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					len = 5'd0;
				end else if (pick < 16) begin
					len = 5'($urandom_range(21, 31));
				end else if (pick < 28) begin
					len  = 5'd8;
					code = 20'(ESC_VAL);
				end
			end else if (pick < 85) begin
				op = OP_ENC;
			end else if (pick < 97) begin
				op = OP_FLUSH;
			end else begin
				op = OP_NONE;
			end
			send_item(op, sym, len, code);
			if (op != OP_NONE)
				counted++;
		end
		calm = 1'b0;

		// Drain and let any stray result show up
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
